// ===== hdl/wer_pkg.sv =====
// wer_pkg: widths and handshake structs shared by the rate estimator modules
// no dependencies
`default_nettype none
package wer_pkg;

  localparam int DEF_DEPTH = 8;
  localparam int MAX_DEPTH = 64;

  localparam int DTW  = 24;
  localparam int IVW  = 32;
  localparam int EVW  = 16;
  localparam int LFW  = 40;
  localparam int OUTW = 32;

  localparam int SUMW  = 38;
  localparam int WW    = 33;
  localparam int SWW   = 39;
  localparam int RNW   = 54;
  localparam int LNW   = 79;
  localparam int MBW   = 32;
  localparam int PRODW = WW + MBW;

  localparam int NUMW = 80;
  localparam int DENW = 40;
  localparam int BITW = 7;

  typedef struct packed {
    logic            start;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
    logic [BITW-1:0] bits;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NUMW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic           we_int;
    logic           we_smp;
    logic [IVW-1:0] interval;
    logic [EVW-1:0] events;
    logic [LFW-1:0] life;
  } mem_wr_t;

  typedef struct packed {
    logic [IVW-1:0] interval;
    logic [EVW-1:0] events;
    logic [LFW-1:0] life;
  } mem_rd_t;

endpackage
`default_nettype wire

// ===== hdl/wer_div.sv =====
// wer_div: restoring divider, one quotient bit per cycle
// depends on wer_pkg
`default_nettype none
module wer_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wer_pkg::div_req_t req,
  output wer_pkg::div_rsp_t      rsp
);

  logic                         busy;
  logic                         done;
  logic [wer_pkg::NUMW-1:0]     num;
  logic [wer_pkg::DENW-1:0]     den;
  logic [wer_pkg::DENW-1:0]     rem;
  logic [wer_pkg::NUMW-1:0]     quo;
  logic [wer_pkg::BITW-1:0]     cnt;
  logic [wer_pkg::DENW:0]       trial;
  logic                         qbit;

  assign trial = {rem, num[wer_pkg::NUMW-1]};
  assign qbit  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= req.bits;
      end else if (busy) begin
        rem <= qbit ? wer_pkg::DENW'(trial - {1'b0, den}) : trial[wer_pkg::DENW-1:0];
        num <= {num[wer_pkg::NUMW-2:0], 1'b0};
        quo <= {quo[wer_pkg::NUMW-2:0], qbit};
        cnt <= cnt - wer_pkg::BITW'(1);
        if (cnt == wer_pkg::BITW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

// ===== hdl/wer_mem.sv =====
// wer_mem: sample window storage, one write and one registered read port
// depends on wer_pkg
`default_nettype none
module wer_mem #(
  parameter int DEPTH = wer_pkg::DEF_DEPTH
) (
  input  wire logic                     clk,
  input  wire wer_pkg::mem_wr_t         wr,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output wer_pkg::mem_rd_t              rd
);

  logic [wer_pkg::IVW-1:0] interval_mem [DEPTH];
  logic [wer_pkg::EVW-1:0] events_mem   [DEPTH];
  logic [wer_pkg::LFW-1:0] life_mem     [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_int) begin
      interval_mem[wr_addr] <= wr.interval;
    end
    if (wr.we_smp) begin
      events_mem[wr_addr] <= wr.events;
      life_mem[wr_addr]   <= wr.life;
    end
    rd.interval <= interval_mem[rd_addr];
    rd.events   <= events_mem[rd_addr];
    rd.life     <= life_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/windowed_event_rate_estimator.sv =====
// windowed_event_rate_estimator: sequencer, accumulators and shared multiplier
// depends on wer_pkg, wer_div, wer_mem
//
// Takes one tick per request and returns one estimate per tick. The block
// handles one request at a time and is not ready while it works. A tick
// sums the intervals of the older stored samples, divides for the mean,
// walks the samples (two serial divisions and four multiply steps each)
// and ends with the final divisions and product. All divisions share the
// one-bit-per-cycle divider. A finished result waits in the output register
// while the next request is taken.
`default_nettype none
module windowed_event_rate_estimator #(
  parameter int WINDOW_DEPTH = wer_pkg::DEF_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [wer_pkg::DTW-1:0]  delta_time,
  input  wire logic [wer_pkg::EVW-1:0]  event_count,
  input  wire logic [wer_pkg::LFW-1:0]  lifetime_total,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [wer_pkg::OUTW-1:0]      rate_estimate,
  output logic [wer_pkg::OUTW-1:0]      life_estimate,
  output logic [wer_pkg::OUTW-1:0]      volume_estimate
);

  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int AW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_NEW   = 20'h00002,
    S_PREP  = 20'h00004,
    S_SUMRD = 20'h00008,
    S_SUMAC = 20'h00010,
    S_MEAN  = 20'h00020,
    S_WRD   = 20'h00040,
    S_WLD   = 20'h00080,
    S_WDIV  = 20'h00100,
    S_PDIV  = 20'h00200,
    S_M0    = 20'h00400,
    S_M1    = 20'h00800,
    S_M2    = 20'h01000,
    S_M3    = 20'h02000,
    S_ADIV  = 20'h04000,
    S_RDIV  = 20'h08000,
    S_LDIV  = 20'h10000,
    S_VOL   = 20'h20000,
    S_VOL2  = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  state_t                      state;
  logic [IW-1:0]               newest;
  logic [AW-1:0]               filled;
  logic [wer_pkg::IVW-1:0]     elapsed;
  logic                        div_issued;

  logic [wer_pkg::EVW-1:0]     cnt_r;
  logic [wer_pkg::LFW-1:0]     life_r;
  logic [IW-1:0]               slot;
  logic [AW-1:0]               age;
  logic [wer_pkg::SUMW-1:0]    sum;
  logic [wer_pkg::SUMW-1:0]    mean;
  logic [wer_pkg::SUMW-1:0]    t;
  logic [wer_pkg::WW-1:0]      w;
  logic [wer_pkg::EVW-1:0]     n;
  logic [wer_pkg::LFW-1:0]     lifev;
  logic [wer_pkg::LFW-1:0]     per;
  logic [wer_pkg::SWW-1:0]     sw;
  logic [wer_pkg::RNW-1:0]     rn;
  logic [wer_pkg::LNW-1:0]     ln;
  logic [wer_pkg::OUTW-1:0]    a;
  logic [wer_pkg::OUTW-1:0]    rate;
  logic [wer_pkg::OUTW-1:0]    life;
  logic [wer_pkg::OUTW-1:0]    vol;
  logic [wer_pkg::PRODW-1:0]   prod;

  logic                        in_fire;
  logic [wer_pkg::IVW:0]       el_sum;
  logic [wer_pkg::IVW-1:0]     el_sat;
  logic [IW-1:0]               newest_inc;
  logic [IW-1:0]               newest_dec;
  logic [IW-1:0]               slot_dec;
  logic [AW-1:0]               filled_m1;
  logic [wer_pkg::WW-1:0]      mul_a;
  logic [wer_pkg::MBW-1:0]     mul_b;
  logic [wer_pkg::OUTW-1:0]    quo_sat;
  logic [wer_pkg::SUMW-1:0]    mean_q;
  logic [wer_pkg::IVW-1:0]     iv;

  wer_pkg::div_req_t           div_req;
  wer_pkg::div_rsp_t           div_rsp;
  wer_pkg::mem_wr_t            mem_wr;
  wer_pkg::mem_rd_t            mem_rd;
  logic [IW-1:0]               wr_addr;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign el_sum = {1'b0, elapsed} + (wer_pkg::IVW + 1)'(delta_time);
  assign el_sat = el_sum[wer_pkg::IVW] ? '1 : el_sum[wer_pkg::IVW-1:0];

  assign newest_inc = (newest == IW'(WINDOW_DEPTH - 1)) ? '0 : newest + IW'(1);
  assign newest_dec = (newest == '0) ? IW'(WINDOW_DEPTH - 1) : newest - IW'(1);
  assign slot_dec   = (slot == '0) ? IW'(WINDOW_DEPTH - 1) : slot - IW'(1);
  assign filled_m1  = filled - AW'(1);

  assign quo_sat = (|div_rsp.quo[wer_pkg::NUMW-1:wer_pkg::OUTW]) ? '1
                   : div_rsp.quo[wer_pkg::OUTW-1:0];
  assign mean_q  = div_rsp.quo[wer_pkg::SUMW-1:0];
  assign iv      = (age == '0) ? elapsed : mem_rd.interval;

  // sample store
  always_comb begin
    mem_wr          = '0;
    mem_wr.interval = el_sat;
    mem_wr.events   = cnt_r;
    mem_wr.life     = life_r;
    wr_addr         = newest;
    if (in_fire && event_count != '0 && filled != '0) begin
      mem_wr.we_int = 1'b1;
    end
    if (state == S_NEW) begin
      mem_wr.we_smp = 1'b1;
      wr_addr       = newest_inc;
    end
  end

  wer_mem #(.DEPTH(WINDOW_DEPTH)) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .wr_addr (wr_addr),
    .rd_addr (slot),
    .rd      (mem_rd)
  );

  // divider operands, left aligned to the bit count
  always_comb begin
    div_req       = '0;
    div_req.start = !div_issued;
    case (state)
      S_MEAN: begin
        div_req.num  = {sum, {(wer_pkg::NUMW - wer_pkg::SUMW){1'b0}}};
        div_req.den  = wer_pkg::DENW'(filled_m1);
        div_req.bits = wer_pkg::BITW'(wer_pkg::SUMW);
      end
      S_WDIV: begin
        div_req.start = !div_issued && (t != '0);
        div_req.num   = {wer_pkg::WW'(64'h1_0000_0000),
                         {(wer_pkg::NUMW - wer_pkg::WW){1'b0}}};
        div_req.den   = wer_pkg::DENW'(t);
        div_req.bits  = wer_pkg::BITW'(wer_pkg::WW);
      end
      S_PDIV: begin
        div_req.num  = {lifev, {(wer_pkg::NUMW - wer_pkg::LFW){1'b0}}};
        div_req.den  = wer_pkg::DENW'(n);
        div_req.bits = wer_pkg::BITW'(wer_pkg::LFW);
      end
      S_ADIV: begin
        div_req.num  = {rn, 16'h0, {(wer_pkg::NUMW - wer_pkg::RNW - 16){1'b0}}};
        div_req.den  = wer_pkg::DENW'(sw);
        div_req.bits = wer_pkg::BITW'(wer_pkg::RNW + 16);
      end
      S_RDIV: begin
        div_req.num  = {a, 16'h0, {(wer_pkg::NUMW - wer_pkg::OUTW - 16){1'b0}}};
        div_req.den  = wer_pkg::DENW'(mean);
        div_req.bits = wer_pkg::BITW'(wer_pkg::OUTW + 16);
      end
      S_LDIV: begin
        div_req.num  = {ln, {(wer_pkg::NUMW - wer_pkg::LNW){1'b0}}};
        div_req.den  = wer_pkg::DENW'(sw);
        div_req.bits = wer_pkg::BITW'(wer_pkg::LNW);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  wer_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = w;
    case (state)
      S_M0:    mul_b = wer_pkg::MBW'(n);
      S_M1:    mul_b = per[31:0];
      S_M2:    mul_b = wer_pkg::MBW'(per[wer_pkg::LFW-1:32]);
      S_VOL: begin
        mul_a = wer_pkg::WW'(rate);
        mul_b = life;
      end
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      newest     <= '0;
      filled     <= '0;
      elapsed    <= '0;
      div_issued <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (div_rsp.done) begin
        div_issued <= 1'b0;
      end else if (div_req.start) begin
        div_issued <= 1'b1;
      end
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            elapsed <= el_sat;
            cnt_r   <= event_count;
            life_r  <= lifetime_total;
            state   <= (event_count != '0) ? S_NEW : S_PREP;
          end
        end
        S_NEW: begin
          newest  <= newest_inc;
          elapsed <= '0;
          if (filled != AW'(WINDOW_DEPTH)) begin
            filled <= filled + AW'(1);
          end
          state <= S_PREP;
        end
        S_PREP: begin
          if (filled < AW'(2)) begin
            rate  <= '0;
            life  <= '0;
            vol   <= '0;
            state <= S_DONE;
          end else begin
            slot  <= newest_dec;
            age   <= AW'(1);
            sum   <= '0;
            state <= S_SUMRD;
          end
        end
        S_SUMRD: begin
          state <= S_SUMAC;
        end
        S_SUMAC: begin
          sum <= sum + wer_pkg::SUMW'(mem_rd.interval);
          if (age == filled_m1) begin
            state <= S_MEAN;
          end else begin
            age   <= age + AW'(1);
            slot  <= slot_dec;
            state <= S_SUMRD;
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            mean <= mean_q;
            t    <= '0;
            sw   <= '0;
            rn   <= '0;
            ln   <= '0;
            if (wer_pkg::SUMW'(elapsed) > mean_q) begin
              age  <= '0;
              slot <= newest;
            end else begin
              age  <= AW'(1);
              slot <= newest_dec;
            end
            state <= S_WRD;
          end
        end
        S_WRD: begin
          state <= S_WLD;
        end
        S_WLD: begin
          t     <= t + wer_pkg::SUMW'(iv);
          n     <= (mem_rd.events == '0) ? wer_pkg::EVW'(1) : mem_rd.events;
          lifev <= mem_rd.life;
          state <= S_WDIV;
        end
        S_WDIV: begin
          if (t == '0) begin
            w     <= wer_pkg::WW'(64'h1_0000_0000);
            state <= S_PDIV;
          end else if (div_rsp.done) begin
            w     <= div_rsp.quo[wer_pkg::WW-1:0];
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            per   <= div_rsp.quo[wer_pkg::LFW-1:0];
            state <= S_M0;
          end
        end
        S_M0: begin
          sw    <= sw + wer_pkg::SWW'(w);
          state <= S_M1;
        end
        S_M1: begin
          rn    <= rn + wer_pkg::RNW'(prod);
          state <= S_M2;
        end
        S_M2: begin
          ln    <= ln + wer_pkg::LNW'(prod);
          state <= S_M3;
        end
        S_M3: begin
          ln <= ln + {prod[wer_pkg::LNW-33:0], 32'h0};
          if (age == filled_m1) begin
            if (sw == '0) begin
              rate  <= '0;
              life  <= '0;
              vol   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_ADIV;
            end
          end else begin
            age   <= age + AW'(1);
            slot  <= slot_dec;
            state <= S_WRD;
          end
        end
        S_ADIV: begin
          if (div_rsp.done) begin
            if (mean == '0 || (|div_rsp.quo[wer_pkg::NUMW-1:wer_pkg::OUTW])) begin
              rate  <= '1;
              state <= S_LDIV;
            end else begin
              a     <= div_rsp.quo[wer_pkg::OUTW-1:0];
              state <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            rate  <= quo_sat;
            state <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_rsp.done) begin
            life  <= quo_sat;
            state <= S_VOL;
          end
        end
        S_VOL: begin
          state <= S_VOL2;
        end
        S_VOL2: begin
          vol   <= prod[63:32];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            rate_estimate   <= rate;
            life_estimate   <= life;
            volume_estimate <= vol;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
